FILE: src/dpbs_pkg.sv
`default_nettype none
package dpbs_pkg;

	localparam logic [63:0] FP_ONE      = 64'h3FF0000000000000;
	localparam logic [63:0] FP_ZERO     = 64'h0000000000000000;
	localparam logic [63:0] FP_NAN_DEF  = 64'hFFF8000000000000;
	localparam logic [63:0] FP_QUIET    = 64'h0008000000000000;
	localparam logic [2:0]  MUL_LAST    = 3'd6;
	localparam logic [5:0]  RCP_LAST    = 6'd59;
	localparam logic [5:0]  RCP_ITER_HI = 6'd57;
	localparam logic [5:0]  RCP_FORM    = 6'd58;

	typedef enum logic [1:0] {
		OUT_ZERO,
		OUT_ONE,
		OUT_ACC
	} out_sel_t;

	typedef struct packed {
		logic     load;
		logic     mul_start;
		logic     mul_sq;
		logic     rcp_start;
		logic     acc_wr;
		logic     base_wr_mul;
		logic     base_wr_rcp;
		logic     mag_shift;
		logic     out_load;
		out_sel_t out_sel;
	} dp_cmd_t;

	typedef struct packed {
		logic mul_done;
		logic rcp_done;
		logic base_zero;
		logic base_one;
		logic exp_neg;
		logic mag_zero;
		logic mag_bit0;
		logic mag_rest_zero;
	} dp_stat_t;

	typedef struct packed {
		logic               sign;
		logic               nan;
		logic               inf;
		logic               zero;
		logic [52:0]        man;
		logic signed [13:0] exp;
	} fp_unpk_t;

	function automatic fp_unpk_t fp_unpack(input logic [63:0] x);
		fp_unpk_t    u;
		logic [10:0] e;
		logic [51:0] f;
		logic [5:0]  lz;
		e = x[62:52];
		f = x[51:0];
		u.sign = x[63];
		u.nan = (e == 11'h7FF) && (f != 52'd0);
		u.inf = (e == 11'h7FF) && (f == 52'd0);
		u.zero = (e == 11'd0) && (f == 52'd0);
		lz = 6'd0;
		for (int i = 0; i < 52; i++) begin
			if (f[i]) begin
				lz = 6'(51 - i);
			end
		end
		if (e != 11'd0) begin
			u.man = {1'b1, f};
			u.exp = $signed({3'b000, e}) - 14'sd1023;
		end else begin
			u.man = {1'b0, f} << (lz + 6'd1);
			u.exp = -14'sd1023 - $signed({8'd0, lz});
		end
		return u;
	endfunction

	function automatic logic [63:0] fp_round(input logic sign, input logic signed [13:0] exp,
			input logic [55:0] sig);
		logic signed [13:0] be;
		logic [13:0]        sh;
		logic [55:0]        s;
		logic [10:0]        eb;
		logic               inc;
		logic [53:0]        mr;
		logic [62:0]        mag;
		be = exp + 14'sd1023;
		sh = 14'd0;
		if (be >= 14'sd1) begin
			eb = be[10:0] - 11'd1;
			s = sig;
		end else begin
			eb = 11'd0;
			sh = 14'(14'sd1 - be);
			if (sh >= 14'd56) begin
				s = {55'd0, |sig};
			end else begin
				s = (sig >> sh[5:0]) | {55'd0, |(sig << (6'd56 - sh[5:0]))};
			end
		end
		inc = s[2] & (s[3] | s[1] | s[0]);
		mr = {1'b0, s[55:3]} + {53'd0, inc};
		mag = {eb, 52'd0} + {9'd0, mr};
		if (be >= 14'sd2047) begin
			return {sign, 11'h7FF, 52'd0};
		end
		return {sign, mag};
	endfunction

endpackage
`default_nettype wire

FILE: src/dpbs_mul.sv
`default_nettype none
module dpbs_mul (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] a,
	input  wire logic [63:0] b,
	output logic             done,
	output logic [63:0]      result
);
	logic                run_q;
	logic [2:0]          cnt_q;
	logic                done_q;
	logic [63:0]         a_q, b_q, res_q, spec_res_q;
	logic                spec_q, sign_q;
	logic [52:0]         ma_q, mb_q;
	logic signed [13:0]  ea_q, eb_q, exp_q;
	logic [105:0]        prod_q;
	logic [55:0]         sig_q;
	dpbs_pkg::fp_unpk_t  ua, ub;
	logic [1:0]          idx;
	logic [26:0]         ah, bh;
	logic [53:0]         pp;
	logic [105:0]        pp_sh;

	assign ua = dpbs_pkg::fp_unpack(a_q);
	assign ub = dpbs_pkg::fp_unpack(b_q);
	assign idx = 2'(cnt_q - 3'd1);
	assign ah = idx[1] ? ma_q[52:26] : {1'b0, ma_q[25:0]};
	assign bh = idx[0] ? mb_q[52:26] : {1'b0, mb_q[25:0]};
	assign pp = 54'(ah) * 54'(bh);

	always_comb begin
		unique case (idx)
			2'd0:    pp_sh = {52'd0, pp};
			2'd1:    pp_sh = {26'd0, pp, 26'd0};
			2'd2:    pp_sh = {26'd0, pp, 26'd0};
			default: pp_sh = {pp, 52'd0};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= 3'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= 3'd0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == dpbs_pkg::MUL_LAST) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
		end else if (run_q) begin
			if (cnt_q == 3'd0) begin
				ma_q <= ua.man;
				mb_q <= ub.man;
				ea_q <= ua.exp;
				eb_q <= ub.exp;
				sign_q <= ua.sign ^ ub.sign;
				prod_q <= 106'd0;
				spec_q <= 1'b1;
				if (ua.nan) begin
					spec_res_q <= a_q | dpbs_pkg::FP_QUIET;
				end else if (ub.nan) begin
					spec_res_q <= b_q | dpbs_pkg::FP_QUIET;
				end else if ((ua.inf && ub.zero) || (ua.zero && ub.inf)) begin
					spec_res_q <= dpbs_pkg::FP_NAN_DEF;
				end else if (ua.inf || ub.inf) begin
					spec_res_q <= {ua.sign ^ ub.sign, 11'h7FF, 52'd0};
				end else if (ua.zero || ub.zero) begin
					spec_res_q <= {ua.sign ^ ub.sign, 63'd0};
				end else begin
					spec_q <= 1'b0;
					spec_res_q <= dpbs_pkg::FP_ZERO;
				end
			end else if (cnt_q <= 3'd4) begin
				prod_q <= prod_q + pp_sh;
			end else if (cnt_q == 3'd5) begin
				if (prod_q[105]) begin
					sig_q <= {prod_q[105:51], prod_q[50] | (|prod_q[49:0])};
					exp_q <= ea_q + eb_q + 14'sd1;
				end else begin
					sig_q <= {prod_q[104:50], prod_q[49] | (|prod_q[48:0])};
					exp_q <= ea_q + eb_q;
				end
			end else begin
				res_q <= spec_q ? spec_res_q : dpbs_pkg::fp_round(sign_q, exp_q, sig_q);
			end
		end
	end

	assign done = done_q;
	assign result = res_q;
endmodule
`default_nettype wire

FILE: src/dpbs_recip.sv
`default_nettype none
module dpbs_recip (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] b,
	output logic             done,
	output logic [63:0]      result
);
	logic                run_q;
	logic [5:0]          cnt_q;
	logic                done_q;
	logic [63:0]         b_q, res_q, spec_res_q;
	logic                spec_q, sign_q;
	logic [52:0]         m_q;
	logic signed [13:0]  eb_q, exp_q;
	logic [53:0]         r_q;
	logic [56:0]         quo_q;
	logic [55:0]         sig_q;
	dpbs_pkg::fp_unpk_t  ub;
	logic                ge;

	assign ub = dpbs_pkg::fp_unpack(b_q);
	assign ge = r_q >= {1'b0, m_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= 6'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= 6'd0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == dpbs_pkg::RCP_LAST) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			b_q <= b;
		end else if (run_q) begin
			if (cnt_q == 6'd0) begin
				m_q <= ub.man;
				eb_q <= ub.exp;
				sign_q <= ub.sign;
				r_q <= 54'd1 << 52;
				quo_q <= 57'd0;
				spec_q <= 1'b1;
				if (ub.nan) begin
					spec_res_q <= b_q | dpbs_pkg::FP_QUIET;
				end else if (ub.inf) begin
					spec_res_q <= {ub.sign, 63'd0};
				end else if (ub.zero) begin
					spec_res_q <= {ub.sign, 11'h7FF, 52'd0};
				end else begin
					spec_q <= 1'b0;
					spec_res_q <= dpbs_pkg::FP_ZERO;
				end
			end else if (cnt_q <= dpbs_pkg::RCP_ITER_HI) begin
				quo_q <= {quo_q[55:0], ge};
				r_q <= ge ? {r_q - {1'b0, m_q}} << 1 : r_q << 1;
			end else if (cnt_q == dpbs_pkg::RCP_FORM) begin
				if (quo_q[56]) begin
					sig_q <= {quo_q[56:2], quo_q[1] | quo_q[0] | (r_q != 54'd0)};
					exp_q <= -eb_q;
				end else begin
					sig_q <= {quo_q[55:1], quo_q[0] | (r_q != 54'd0)};
					exp_q <= -eb_q - 14'sd1;
				end
			end else begin
				res_q <= spec_q ? spec_res_q : dpbs_pkg::fp_round(sign_q, exp_q, sig_q);
			end
		end
	end

	assign done = done_q;
	assign result = res_q;
endmodule
`default_nettype wire

FILE: src/dpbs_dpath.sv
`default_nettype none
module dpbs_dpath (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire dpbs_pkg::dp_cmd_t  cmd,
	input  wire logic [63:0]        base_bits,
	input  wire logic signed [31:0] exponent,
	output dpbs_pkg::dp_stat_t      stat,
	output logic [63:0]             power_bits
);
	logic [63:0] base_q, acc_q, power_q;
	logic [31:0] mag_q;
	logic        neg_q;
	logic [63:0] mul_a, mul_res, rcp_res;
	logic        mul_done, rcp_done;

	assign mul_a = cmd.mul_sq ? base_q : acc_q;

	dpbs_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul_start),
		.a      (mul_a),
		.b      (base_q),
		.done   (mul_done),
		.result (mul_res)
	);

	dpbs_recip u_recip (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.rcp_start),
		.b      (base_q),
		.done   (rcp_done),
		.result (rcp_res)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			base_q <= base_bits;
			acc_q <= dpbs_pkg::FP_ONE;
			neg_q <= exponent[31];
			mag_q <= exponent[31] ? 32'(-exponent) : 32'(exponent);
		end else begin
			if (cmd.base_wr_rcp) begin
				base_q <= rcp_res;
			end else if (cmd.base_wr_mul) begin
				base_q <= mul_res;
			end
			if (cmd.acc_wr) begin
				acc_q <= mul_res;
			end
			if (cmd.mag_shift) begin
				mag_q <= mag_q >> 1;
			end
		end
		if (cmd.out_load) begin
			unique case (cmd.out_sel)
				dpbs_pkg::OUT_ZERO: power_q <= dpbs_pkg::FP_ZERO;
				dpbs_pkg::OUT_ONE:  power_q <= dpbs_pkg::FP_ONE;
				default:            power_q <= acc_q;
			endcase
		end
	end

	assign stat.mul_done = mul_done;
	assign stat.rcp_done = rcp_done;
	assign stat.base_zero = base_q[62:0] == 63'd0;
	assign stat.base_one = base_q == dpbs_pkg::FP_ONE;
	assign stat.exp_neg = neg_q;
	assign stat.mag_zero = mag_q == 32'd0;
	assign stat.mag_bit0 = mag_q[0];
	assign stat.mag_rest_zero = mag_q[31:1] == 31'd0;
	assign power_bits = power_q;
endmodule
`default_nettype wire

FILE: src/dpbs_ctrl.sv
`default_nettype none
module dpbs_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	output logic                    out_valid,
	input  wire logic               out_ready,
	input  wire dpbs_pkg::dp_stat_t stat,
	output dpbs_pkg::dp_cmd_t       cmd
);
	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_RCP,
		S_STEP,
		S_MUL,
		S_SQ
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready = state_q == S_IDLE;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		cmd.out_sel = dpbs_pkg::OUT_ACC;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (stat.base_zero || stat.base_one) begin
					if (slot_free) begin
						cmd.out_load = 1'b1;
						cmd.out_sel = stat.base_zero ? dpbs_pkg::OUT_ZERO : dpbs_pkg::OUT_ONE;
						state_d = S_IDLE;
					end
				end else if (stat.exp_neg) begin
					cmd.rcp_start = 1'b1;
					state_d = S_RCP;
				end else begin
					state_d = S_STEP;
				end
			end
			S_RCP: begin
				if (stat.rcp_done) begin
					cmd.base_wr_rcp = 1'b1;
					state_d = S_STEP;
				end
			end
			S_STEP: begin
				if (stat.mag_zero) begin
					if (slot_free) begin
						cmd.out_load = 1'b1;
						state_d = S_IDLE;
					end
				end else if (stat.mag_bit0) begin
					cmd.mul_start = 1'b1;
					state_d = S_MUL;
				end else begin
					cmd.mul_start = 1'b1;
					cmd.mul_sq = 1'b1;
					state_d = S_SQ;
				end
			end
			S_MUL: begin
				if (stat.mul_done) begin
					cmd.acc_wr = 1'b1;
					if (stat.mag_rest_zero) begin
						cmd.mag_shift = 1'b1;
						state_d = S_STEP;
					end else begin
						cmd.mul_start = 1'b1;
						cmd.mul_sq = 1'b1;
						state_d = S_SQ;
					end
				end
			end
			S_SQ: begin
				if (stat.mul_done) begin
					cmd.base_wr_mul = 1'b1;
					cmd.mag_shift = 1'b1;
					state_d = S_STEP;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

FILE: src/double_power_by_squaring_unit.sv
// channel | signals                              | word
// input   | in_valid, in_ready                   | base_bits[63:0], exponent[31:0] (signed)
// output  | out_valid, out_ready                 | power_bits[63:0]
//
// One word at a time. A zero or unit base goes from the check state straight to
// the output register. Otherwise a negative exponent first replaces the base by
// its reciprocal; then each magnitude bit takes a multiply when set and a squaring
// unless no higher bit is left, both on the shared double multiplier.
// Reset clears the controller and the valid flag; a held output word stalls the
// last step, while the next input word is taken and worked on.
`default_nettype none
module double_power_by_squaring_unit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [63:0]        base_bits,
	input  wire logic signed [31:0] exponent,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [63:0]             power_bits
);
	dpbs_pkg::dp_cmd_t  cmd;
	dpbs_pkg::dp_stat_t stat;

	dpbs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	dpbs_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.base_bits  (base_bits),
		.exponent   (exponent),
		.stat       (stat),
		.power_bits (power_bits)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken twice in a row");

	a_units_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(stat.mul_done && stat.rcp_done))
		else $error("multiplier and reciprocal finished together");

	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared without work");

	a_load_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid || out_ready))
		else $error("output register overwritten");
endmodule
`default_nettype wire
